// ===== src/iac_pkg.sv =====
// Package for the interpolated aperture check block.
// Holds table sizing, field widths, codes, the queued item and result types.
// No dependencies.
`default_nettype none
package iac_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);

  localparam int WEIGHT_BITS = 23;
  localparam int W_W         = WEIGHT_BITS + 1;
  localparam int CNT_W       = $clog2(WEIGHT_BITS + 1);

  localparam int POS_W = 40;
  localparam int DIM_W = 31;
  localparam int XY_W  = 32;
  localparam int Z_W   = 41;
  localparam int IDX_W = 10;
  localparam int LENCFG_W = 11;
  localparam int SHAPE_W  = 2;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 1;

  localparam int IN_DATA_W  = 280;
  localparam int OUT_DATA_W = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_APERTURE_SHAPE = 1'd1;

  localparam logic [SHAPE_W-1:0] SHAPE_RECT_ELLIPSE = 2'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_CIRCLE       = 2'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_ELLIPSE      = 2'd2;

  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_RANGE  = 2'd1;
  localparam logic [1:0] ERR_ZERO_R = 2'd2;

  typedef struct packed {
    logic               op;
    logic [IDX_W-1:0]   idx;
    logic [POS_W-1:0]   s;
    logic [DIM_W-1:0]   ap1;
    logic [DIM_W-1:0]   ap2;
    logic [DIM_W-1:0]   ap3;
    logic [DIM_W-1:0]   ap4;
    logic [XY_W-1:0]    ax;
    logic [XY_W-1:0]    ay;
    logic [POS_W-1:0]   z;
  } iac_item_t;

  typedef struct packed {
    logic [1:0] error_code;
    logic       fast_accept;
    logic       inside_res;
  } iac_result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FETCH0,
    ST_FETCH1,
    ST_FETCH2,
    ST_EVAL,
    ST_DIVIDE,
    ST_MUL,
    ST_ACC,
    ST_FINAL,
    ST_DONE
  } back_state_t;

endpackage
`default_nettype wire

// ===== src/interpolated_aperture_check.sv =====
// Top level of the interpolated aperture check: configuration registers,
// front end queue and back end sequencer. Uses iac_pkg, iac_front, iac_back.
//
// A load transaction (tuser 0) writes one table entry as it leaves the queue.
// A check transaction (tuser 1) leaves the queue and then walks the position
// memory one entry a cycle from entry 1 up to the first entry n below the
// table length with s at or beyond z. With no such entry the walk covers the
// whole table length and the result is a range error. A fast accept or a zero
// radius ends the check after both entries are fetched. A full test adds a
// bit-serial weight division of up to 23 quotient bits and one product at a
// time on the shared 32x32 multiplier: 7 products for the circle, 20 for the
// ellipse shapes. A two-entry queue keeps taking transactions while the back end
// works or while a result waits on out_tready, until it is full. Table memory
// contents are undefined until written.
`default_nettype none
module interpolated_aperture_check (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // tdata: entry_index, entry_s, entry_ap1, entry_ap2, entry_ap3, entry_ap4,
  //        particle_x, particle_y, particle_z, zero pad
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [iac_pkg::IN_DATA_W-1:0]   in_tdata,
  // tuser: operation
  input  wire logic                            in_tuser,
  // tdata: inside_res, fast_accept, error_code, zero pad
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [iac_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [iac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [iac_pkg::CFG_W-1:0]       cfg_wdata
);
  import iac_pkg::*;

  logic [LENCFG_W-1:0] table_length_r;
  logic [SHAPE_W-1:0]  aperture_shape_r;
  logic                q_valid, q_pop;
  iac_item_t           q_item;
  iac_result_t         res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_length_r   <= '0;
      aperture_shape_r <= SHAPE_RECT_ELLIPSE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TABLE_LENGTH:   table_length_r   <= cfg_wdata[LENCFG_W-1:0];
        CFG_APERTURE_SHAPE: aperture_shape_r <= cfg_wdata[SHAPE_W-1:0];
        default: ;
      endcase
    end
  end

  iac_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  iac_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .table_length   (table_length_r),
    .aperture_shape (aperture_shape_r),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_tvalid),
    .out_res        (res),
    .out_ready      (out_tready)
  );

  assign out_tdata = {4'b0, res.error_code, res.fast_accept, res.inside_res};

`ifndef NO_ASSERTIONS
  a_err_clears_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res.error_code != ERR_OK) |-> !res.inside_res && !res.fast_accept)
    else $error("error result carries inside or fast accept");

  a_fast_is_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.fast_accept |-> res.inside_res && (res.error_code == ERR_OK))
    else $error("fast accept without inside");

  a_err_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res.error_code == ERR_OK) || (res.error_code == ERR_RANGE) ||
                   (res.error_code == ERR_ZERO_R))
    else $error("unknown error code");
`endif

endmodule
`default_nettype wire

// ===== src/iac_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module iac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/iac_front.sv =====
// Front end: accepts input transactions, takes |x|, |y| and clamps z,
// and holds the items in a short queue for the back end. Uses iac_pkg.
`default_nettype none
module iac_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [iac_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                           in_tuser,
  output logic                                q_valid,
  output iac_pkg::iac_item_t                  q_item,
  input  wire logic                           q_pop
);
  import iac_pkg::*;

  iac_item_t            item_in;
  iac_item_t            q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r;
  logic [QPTR_W-1:0]    rd_ptr_r;
  logic [QCNT_W-1:0]    count_r;
  logic                 push;
  logic [XY_W-1:0]      x_raw;
  logic [XY_W-1:0]      y_raw;
  logic [Z_W-1:0]       z_raw;

  assign x_raw = in_tdata[205:174];
  assign y_raw = in_tdata[237:206];
  assign z_raw = in_tdata[278:238];

  always_comb begin
    item_in.op  = in_tuser;
    item_in.idx = in_tdata[9:0];
    item_in.s   = in_tdata[49:10];
    item_in.ap1 = in_tdata[80:50];
    item_in.ap2 = in_tdata[111:81];
    item_in.ap3 = in_tdata[142:112];
    item_in.ap4 = in_tdata[173:143];
    item_in.ax  = x_raw[XY_W-1] ? (~x_raw + 1'b1) : x_raw;
    item_in.ay  = y_raw[XY_W-1] ? (~y_raw + 1'b1) : y_raw;
    item_in.z   = z_raw[Z_W-1] ? '0 : z_raw[POS_W-1:0];
  end

  assign in_tready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign q_item    = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, q_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/iac_back.sv =====
// Back end: table writes, segment search, interpolation, aperture tests
// and the output register. Uses iac_pkg and iac_ram.
`default_nettype none
module iac_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [iac_pkg::LENCFG_W-1:0]    table_length,
  input  wire logic [iac_pkg::SHAPE_W-1:0]     aperture_shape,
  input  wire logic                            q_valid,
  input  iac_pkg::iac_item_t                   q_item,
  output logic                                 q_pop,
  output logic                                 out_valid,
  output iac_pkg::iac_result_t                 out_res,
  input  wire logic                            out_ready
);
  import iac_pkg::*;

  localparam logic [4:0] STEP_LERP_LAST = 5'd3;
  localparam logic [4:0] STEP_SQ_X      = 5'd4;
  localparam logic [4:0] STEP_SQ_Y      = 5'd5;
  localparam logic [4:0] STEP_SQ_A      = 5'd6;
  localparam logic [4:0] STEP_SQ_B      = 5'd7;
  localparam logic [4:0] STEP_XB_FIRST  = 5'd8;
  localparam logic [4:0] STEP_YA_FIRST  = 5'd12;
  localparam logic [4:0] STEP_AB_FIRST  = 5'd16;
  localparam logic [4:0] STEP_AB_LAST   = 5'd19;
  localparam int DIMS_W = 4 * DIM_W;

  back_state_t state_r, state_nxt;

  logic [XY_W-1:0]   ax_r, ay_r;
  logic [POS_W-1:0]  z_r, sf_r, sb_r, rem_r;
  logic [LEN_W-1:0]  k_r, len;
  logic              pend_r;
  logic [ADDR_W-1:0] pend_k_r, n_r;
  logic [DIM_W-1:0]  df_r [4];
  logic [DIM_W-1:0]  db_r [4];
  logic [DIM_W-1:0]  ad_r [4];
  logic [W_W-1:0]    w_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [4:0]        step_r, step_last;
  logic [63:0]       prod_r, xsq_r, ysq_r;
  logic [61:0]       asq_r, bsq_r;
  logic [127:0]      lhs_r, rhs_r;
  iac_result_t       res_r, res_nxt;
  logic              out_valid_r;
  iac_result_t       out_r;

  logic              pos_we, dim_we;
  logic [ADDR_W-1:0] wr_addr, pos_raddr, dim_raddr;
  logic [POS_W-1:0]  pos_rdata;
  logic [DIMS_W-1:0] dim_rdata, dim_wdata;
  logic              idx_ok, hit, issue;

  logic [DIM_W-1:0]  m1, m2, m3, m4, m12, m34, mn;
  logic              zero_r, fast;
  logic [XY_W:0]     absum;
  logic [POS_W-1:0]  u, delta;
  logic [POS_W:0]    rem2;
  logic              div_bit;

  logic [1:0]        lk, sub;
  logic [DIM_W-1:0]  ldf, ldb, ldiff, corr;
  logic [DIM_W-1:0]  ea, eb;
  logic [63:0]       bsq64, asq64;
  logic [31:0]       op_a, op_b;
  logic [6:0]        shamt;
  logic [127:0]      prod_sh;
  logic              inside_fin;
  logic              is_circle, is_ellipse;

  function automatic logic [31:0] half64(input logic [63:0] v, input logic hi);
    return hi ? v[63:32] : v[31:0];
  endfunction

  function automatic logic [DIM_W-1:0] min2(input logic [DIM_W-1:0] a,
                                            input logic [DIM_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  iac_ram #(.WIDTH(POS_W), .DEPTH(TABLE_DEPTH)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (wr_addr),
    .wdata (q_item.s),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  iac_ram #(.WIDTH(DIMS_W), .DEPTH(TABLE_DEPTH)) u_dim_ram (
    .clk   (clk),
    .we    (dim_we),
    .waddr (wr_addr),
    .wdata (dim_wdata),
    .raddr (dim_raddr),
    .rdata (dim_rdata)
  );

  assign is_circle  = (aperture_shape == SHAPE_CIRCLE);
  assign is_ellipse = (aperture_shape == SHAPE_ELLIPSE);
  assign len        = (32'(table_length) > TABLE_DEPTH) ? LEN_W'(TABLE_DEPTH)
                                                         : LEN_W'(table_length);
  assign idx_ok     = (32'(q_item.idx) < TABLE_DEPTH);
  assign wr_addr    = ADDR_W'(q_item.idx);
  assign dim_wdata  = {q_item.ap4, q_item.ap3, q_item.ap2, q_item.ap1};
  assign issue      = (k_r < len);
  assign hit        = pend_r && (pos_rdata >= z_r);

  // classification of the fetched segment
  always_comb begin
    m1  = min2(df_r[0], db_r[0]);
    m2  = min2(df_r[1], db_r[1]);
    m3  = min2(df_r[2], db_r[2]);
    m4  = min2(df_r[3], db_r[3]);
    m12 = min2(m1, m2);
    m34 = min2(m3, m4);
    if (is_circle) begin
      mn     = m1;
      zero_r = (m1 == '0);
    end else if (is_ellipse) begin
      mn     = m12;
      zero_r = (m12 == '0);
    end else begin
      mn     = min2(m12, m34);
      zero_r = (m3 == '0) || (m4 == '0);
    end
    absum = {1'b0, ax_r} + {1'b0, ay_r};
    fast  = (absum < (XY_W + 1)'(mn));
    u     = sf_r - z_r;
    delta = sf_r - sb_r;
  end

  assign rem2    = {rem_r, 1'b0};
  assign div_bit = (rem2 >= {1'b0, delta});

  // multiplier operand selection
  always_comb begin
    lk    = step_r[1:0];
    sub   = 2'(step_r - STEP_XB_FIRST);
    ldf   = df_r[lk];
    ldb   = db_r[lk];
    ldiff = (ldb >= ldf) ? (ldb - ldf) : (ldf - ldb);
    corr  = prod_r[WEIGHT_BITS + DIM_W - 1:WEIGHT_BITS];
    ea    = (is_circle || is_ellipse) ? ad_r[0] : ad_r[2];
    eb    = is_ellipse ? ad_r[1] : ad_r[3];
    bsq64 = {2'b0, bsq_r};
    asq64 = {2'b0, asq_r};
    priority if (step_r <= STEP_LERP_LAST) begin
      op_a = 32'(ldiff);
      op_b = 32'(w_r);
    end else if (step_r == STEP_SQ_X) begin
      op_a = ax_r;
      op_b = ax_r;
    end else if (step_r == STEP_SQ_Y) begin
      op_a = ay_r;
      op_b = ay_r;
    end else if (step_r == STEP_SQ_A) begin
      op_a = 32'(ea);
      op_b = 32'(ea);
    end else if (step_r == STEP_SQ_B) begin
      op_a = 32'(eb);
      op_b = 32'(eb);
    end else if (step_r < STEP_YA_FIRST) begin
      op_a = half64(xsq_r, sub[1]);
      op_b = half64(bsq64, sub[0]);
    end else if (step_r < STEP_AB_FIRST) begin
      op_a = half64(ysq_r, sub[1]);
      op_b = half64(asq64, sub[0]);
    end else begin
      op_a = half64(asq64, sub[1]);
      op_b = half64(bsq64, sub[0]);
    end
    shamt   = {2'(sub[1]) + 2'(sub[0]), 5'd0};
    prod_sh = {64'd0, prod_r} << shamt;
    step_last = is_circle ? STEP_SQ_A : STEP_AB_LAST;
  end

  always_comb begin
    if (is_circle) begin
      inside_fin = ({1'b0, xsq_r} + {1'b0, ysq_r}) < {3'b0, asq_r};
    end else if (is_ellipse) begin
      inside_fin = (lhs_r <= rhs_r);
    end else begin
      inside_fin = (lhs_r <= rhs_r) && (ax_r <= 32'(ad_r[0])) && (ay_r <= 32'(ad_r[1]));
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && (q_item.op == OP_CHECK)) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        priority if (hit) begin
          state_nxt = ST_FETCH0;
        end else if (!issue) begin
          state_nxt = ST_DONE;
        end
      end
      ST_FETCH0: state_nxt = ST_FETCH1;
      ST_FETCH1: state_nxt = ST_FETCH2;
      ST_FETCH2: state_nxt = ST_EVAL;
      ST_EVAL: begin
        priority if (fast || zero_r) begin
          state_nxt = ST_DONE;
        end else if ((sf_r > sb_r) && (u < delta)) begin
          state_nxt = ST_DIVIDE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_DIVIDE: begin
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: state_nxt = (step_r == step_last) ? ST_FINAL : ST_MUL;
      ST_FINAL: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop     = 1'b0;
    pos_we    = 1'b0;
    dim_we    = 1'b0;
    pos_raddr = k_r[ADDR_W-1:0];
    dim_raddr = n_r;
    unique case (state_r)
      ST_IDLE: begin
        q_pop = q_valid;
        if (q_valid && (q_item.op == OP_WRITE) && idx_ok) begin
          pos_we = 1'b1;
          dim_we = 1'b1;
        end
      end
      ST_FETCH0: pos_raddr = n_r - 1'b1;
      ST_FETCH1: dim_raddr = n_r - 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    res_nxt = res_r;
    unique case (state_r)
      ST_IDLE: res_nxt = '{error_code: ERR_OK, fast_accept: 1'b0, inside_res: 1'b0};
      ST_SEARCH: begin
        if (!hit && !issue) begin
          res_nxt.error_code = ERR_RANGE;
        end
      end
      ST_EVAL: begin
        priority if (fast) begin
          res_nxt.inside_res  = 1'b1;
          res_nxt.fast_accept = 1'b1;
        end else if (zero_r) begin
          res_nxt.error_code = ERR_ZERO_R;
        end
      end
      ST_FINAL: res_nxt.inside_res = inside_fin;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    unique case (state_r)
      ST_IDLE: begin
        ax_r   <= q_item.ax;
        ay_r   <= q_item.ay;
        z_r    <= q_item.z;
        k_r    <= LEN_W'(1);
        pend_r <= 1'b0;
      end
      ST_SEARCH: begin
        pend_r   <= issue;
        pend_k_r <= k_r[ADDR_W-1:0];
        k_r      <= k_r + 1'b1;
        n_r      <= pend_k_r;
        sf_r     <= pos_rdata;
      end
      ST_FETCH1: begin
        sb_r <= pos_rdata;
        for (int i = 0; i < 4; i++) begin
          df_r[i] <= dim_rdata[i*DIM_W +: DIM_W];
        end
      end
      ST_FETCH2: begin
        for (int i = 0; i < 4; i++) begin
          db_r[i] <= dim_rdata[i*DIM_W +: DIM_W];
        end
      end
      ST_EVAL: begin
        step_r <= '0;
        lhs_r  <= '0;
        rhs_r  <= '0;
        rem_r  <= u;
        cnt_r  <= CNT_W'(WEIGHT_BITS);
        priority if (sf_r <= sb_r) begin
          w_r <= '0;
        end else if (u >= delta) begin
          w_r <= W_W'(1) << WEIGHT_BITS;
        end else begin
          w_r <= '0;
        end
      end
      ST_DIVIDE: begin
        rem_r <= div_bit ? POS_W'(rem2 - {1'b0, delta}) : rem2[POS_W-1:0];
        w_r   <= {w_r[W_W-2:0], div_bit};
        cnt_r <= cnt_r - 1'b1;
      end
      ST_MUL: prod_r <= op_a * op_b;
      ST_ACC: begin
        step_r <= step_r + 1'b1;
        priority if (step_r <= STEP_LERP_LAST) begin
          ad_r[lk] <= (ldb >= ldf) ? (ldf + corr) : (ldf - corr);
        end else if (step_r == STEP_SQ_X) begin
          xsq_r <= prod_r;
        end else if (step_r == STEP_SQ_Y) begin
          ysq_r <= prod_r;
        end else if (step_r == STEP_SQ_A) begin
          asq_r <= prod_r[61:0];
        end else if (step_r == STEP_SQ_B) begin
          bsq_r <= prod_r[61:0];
        end else if (step_r < STEP_AB_FIRST) begin
          lhs_r <= lhs_r + prod_sh;
        end else begin
          rhs_r <= rhs_r + prod_sh;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && (!out_valid_r || out_ready)) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule
`default_nettype wire

// ===== tb/iac_checker.sv =====
// Checker for the interpolated aperture check: watches the input, result and
// configuration ports, predicts each check result and compares it. Uses iac_pkg.
`timescale 1ns / 100ps
module iac_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [iac_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [iac_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_we,
  input  logic [iac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [iac_pkg::CFG_W-1:0]      cfg_wdata,
  output int                             fail_count,
  output int                             pending
);
  import iac_pkg::*;

  bit [POS_W-1:0] pos_mem [TABLE_DEPTH];
  bit [DIM_W-1:0] dim_mem [4][TABLE_DEPTH];
  bit [LENCFG_W-1:0] table_len;
  bit [SHAPE_W-1:0]  shape;
  iac_result_t expected_q[$];
  int fails;

  assign fail_count = fails;
  assign pending    = expected_q.size();

  function automatic bit [63:0] lerp_dim(bit [63:0] f, bit [63:0] b, bit [63:0] w);
    if (b >= f) return f + (((b - f) * w) >> WEIGHT_BITS);
    return f - (((f - b) * w) >> WEIGHT_BITS);
  endfunction

  function automatic bit in_ellipse(bit [63:0] x2, bit [63:0] y2, bit [63:0] a,
                                    bit [63:0] b);
    bit [127:0] lhs, rhs;
    lhs = 128'(x2) * 128'(b * b) + 128'(y2) * 128'(a * a);
    rhs = 128'(a * a) * 128'(b * b);
    return lhs <= rhs;
  endfunction

  function automatic iac_result_t predict_check(bit [31:0] xv, bit [31:0] yv, bit [40:0] zv);
    iac_result_t r;
    bit [63:0] ax, ay, zc, mn, w, sf, sb, delta, u, x2, y2;
    bit [63:0] fd [4];
    bit [63:0] bd [4];
    bit [63:0] ap [4];
    int len, n;
    bit found, zero_r, ins;
    r = '0;
    found = 0;
    n = 0;
    ax = xv[31] ? (64'h1_0000_0000 - xv) : xv;
    ay = yv[31] ? (64'h1_0000_0000 - yv) : yv;
    zc = zv[40] ? 64'd0 : zv[39:0];
    len = (table_len > TABLE_DEPTH) ? TABLE_DEPTH : table_len;
    for (int k = 1; k < len; k++) begin
      if (pos_mem[k] >= zc) begin
        n = k;
        found = 1;
        break;
      end
    end
    if (!found) begin
      r.error_code = ERR_RANGE;
      return r;
    end
    for (int d = 0; d < 4; d++) begin
      fd[d] = dim_mem[d][n];
      bd[d] = dim_mem[d][n-1];
    end
    mn = (fd[0] < bd[0]) ? fd[0] : bd[0];
    case (shape)
      SHAPE_CIRCLE: zero_r = (mn == 0);
      SHAPE_ELLIPSE: begin
        for (int d = 1; d < 2; d++) begin
          if (fd[d] < mn) mn = fd[d];
          if (bd[d] < mn) mn = bd[d];
        end
        zero_r = (mn == 0);
      end
      default: begin
        for (int d = 1; d < 4; d++) begin
          if (fd[d] < mn) mn = fd[d];
          if (bd[d] < mn) mn = bd[d];
        end
        zero_r = fd[2] == 0 || bd[2] == 0 || fd[3] == 0 || bd[3] == 0;
      end
    endcase
    if (ax + ay < mn) begin
      r.inside_res = 1;
      r.fast_accept = 1;
      return r;
    end
    if (zero_r) begin
      r.error_code = ERR_ZERO_R;
      return r;
    end
    sf = pos_mem[n];
    sb = pos_mem[n-1];
    if (sf <= sb) begin
      w = 0;
    end else begin
      delta = sf - sb;
      u = sf - zc;
      w = (u >= delta) ? (64'd1 << WEIGHT_BITS) : ((u << WEIGHT_BITS) / delta);
    end
    for (int d = 0; d < 4; d++) ap[d] = lerp_dim(fd[d], bd[d], w);
    x2 = ax * ax;
    y2 = ay * ay;
    case (shape)
      SHAPE_CIRCLE:  ins = (x2 + y2) < ap[0] * ap[0];
      SHAPE_ELLIPSE: ins = in_ellipse(x2, y2, ap[0], ap[1]);
      default:       ins = in_ellipse(x2, y2, ap[2], ap[3]) && ax <= ap[0] && ay <= ap[1];
    endcase
    r.inside_res = ins;
    return r;
  endfunction

  always @(posedge clk) begin
    iac_result_t got, want;
    if (!rst_n) begin
      table_len = '0;
      shape = '0;
      fails = 0;
      expected_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[3:0];
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction %h", out_tdata);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (got.inside_res !== want.inside_res) begin
            $error("inside_res: expected %0d, got %0d", want.inside_res, got.inside_res);
            fails++;
          end
          if (got.fast_accept !== want.fast_accept) begin
            $error("fast_accept: expected %0d, got %0d", want.fast_accept, got.fast_accept);
            fails++;
          end
          if (got.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
            fails++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_CHECK) begin
          expected_q.insert(expected_q.size(),
                            predict_check(in_tdata[205:174], in_tdata[237:206],
                                          in_tdata[278:238]));
        end else begin
          pos_mem[in_tdata[9:0]] = in_tdata[49:10];
          dim_mem[0][in_tdata[9:0]] = in_tdata[80:50];
          dim_mem[1][in_tdata[9:0]] = in_tdata[111:81];
          dim_mem[2][in_tdata[9:0]] = in_tdata[142:112];
          dim_mem[3][in_tdata[9:0]] = in_tdata[173:143];
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TABLE_LENGTH:   table_len = cfg_wdata[LENCFG_W-1:0];
          CFG_APERTURE_SHAPE: shape = cfg_wdata[SHAPE_W-1:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== tb/interpolated_aperture_check_tb.sv =====
// Top of the interpolated aperture check testbench: clock, reset, table loads,
// particle checks, configuration phases and the verdict. Uses iac_pkg, iac_checker.
`timescale 1ns / 100ps
module interpolated_aperture_check_tb;
  import iac_pkg::*;

  localparam logic [SHAPE_W-1:0] SHAPE_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 1300;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  int fail_count, pending;

  bit [POS_W-1:0] s_tab [TABLE_DEPTH];
  int written_top = 0;
  int sent = 0;
  int dim_bits = 31;
  bit no_gaps = 0;
  bit long_hold_req = 0;

  always #5 clk = ~clk;

  interpolated_aperture_check dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  iac_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random stalls, plus one long hold when requested
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 0;
        hold = 400;
      end else if (hold == 0 && !no_gaps && $urandom_range(0, 99) < 30) begin
        hold = pick_gap();
      end
      if (hold > 0) begin
        out_tready <= 0;
        hold--;
      end else begin
        out_tready <= 1;
      end
    end
  end

  task automatic push(input logic op, input logic [IN_DATA_W-1:0] d);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic load_entry(input int idx, input bit [39:0] s, input bit [30:0] a1,
                            input bit [30:0] a2, input bit [30:0] a3, input bit [30:0] a4);
    push(OP_WRITE, {1'b0, 41'd0, 32'd0, 32'd0, a4, a3, a2, a1, s, 10'(idx)});
    s_tab[idx] = s;
    if (idx == written_top) written_top++;
    while (written_top < TABLE_DEPTH && written_top > idx && s_tab[written_top] !== 'x
           && 0) written_top++;
  endtask

  task automatic check_particle(input bit [31:0] x, input bit [31:0] y, input bit [40:0] z);
    push(OP_CHECK, {1'b0, z, y, x, 124'd0, 40'd0, 10'd0});
  endtask

  task automatic drain();
    in_tvalid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic bit [30:0] rand_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 31'd0;
    if (r < 8) return 31'h7FFF_FFFF;
    return 31'($urandom_range(1, 32'h7FFF_FFFF) >> (31 - dim_bits));
  endfunction

  function automatic bit [31:0] rand_coord();
    int r;
    bit [31:0] m;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom();
    if (r < 13) return 32'h8000_0000;
    if (r < 15) return 32'h7FFF_FFFF;
    m = 32'($urandom_range(0, 32'h7FFF_FFFF) >> (31 - dim_bits));
    if (r < 25) m = 0;
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic bit [40:0] rand_z(input int len);
    int r, k;
    bit [40:0] off;
    r = $urandom_range(0, 99);
    k = (len > 0) ? $urandom_range(0, len - 1) : 0;
    off = 41'($urandom_range(0, 1 << 20));
    if (r < 12) return {1'b1, 40'($urandom()) ^ {8'($urandom()), 32'd0}};
    if (r < 22) return {$urandom_range(0, 1) == 1, 8'($urandom()), 32'($urandom())};
    if (r < 32) return {1'b0, s_tab[k]};
    if (r < 40) return {1'b0, s_tab[(len > 0) ? len - 1 : 0]} + off + 1;
    if (r < 70) return {1'b0, s_tab[k]} + off;
    return {1'b0, s_tab[k]} - off;
  endfunction

  task automatic load_table(input int len, input int step_bits);
    bit [39:0] s;
    int r;
    s = 40'($urandom_range(0, 1000));
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (i > 0) begin
        if (r < 5) s = s;
        else if (r < 9) s = s - 40'($urandom_range(1, 1 << step_bits));
        else s = s + 40'($urandom_range(1, 1 << step_bits));
      end
      load_entry(i, s, rand_dim(), rand_dim(), rand_dim(), rand_dim());
    end
  endtask

  task automatic run_checks(input int cnt, input int len);
    for (int i = 0; i < cnt; i++) begin
      if (len > 0 && $urandom_range(0, 9) == 0)
        load_entry($urandom_range(0, written_top - 1), s_tab[$urandom_range(0, len - 1)],
                   rand_dim(), rand_dim(), rand_dim(), rand_dim());
      check_particle(rand_coord(), rand_coord(), rand_z(len));
    end
  endtask

  initial begin
    int len, shp;
    bit did_hold;
    did_hold = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    write_reg(CFG_TABLE_LENGTH, 0);
    write_reg(CFG_APERTURE_SHAPE, SHAPE_RECT_ELLIPSE);

    // directed: empty table, then a tiny table with equal, reversed and zero entries
    check_particle(32'd0, 32'd0, 41'd5);
    load_entry(0, 40'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    load_entry(1, 40'd1000, 31'd1000, 31'd2000, 31'd3000, 31'd4000);
    load_entry(2, 40'd1000, 31'd500, 31'd600, 31'd700, 31'd800);
    load_entry(3, 40'd600, 31'd5000, 31'd5000, 31'd5000, 31'd5000);
    load_entry(4, 40'hFF_FFFF_FFFF, 31'd900, 31'd900, 31'd0, 31'd900);
    drain();
    write_reg(CFG_TABLE_LENGTH, 1);
    check_particle(32'd0, 32'd0, 41'd0);
    drain();
    write_reg(CFG_TABLE_LENGTH, 5);
    for (int sh = 0; sh < 4; sh++) begin
      write_reg(CFG_APERTURE_SHAPE, sh);
      check_particle(32'd10, 32'hFFFF_FFF0, {1'b1, 40'd0});
      check_particle(32'h8000_0000, 32'h7FFF_FFFF, 41'd500);
      check_particle(32'd1500, 32'd100, 41'd1000);
      check_particle(32'd2000, 32'd2000, 41'h0FF_FFFF_FFFF);
      drain();
    end

    while (sent < 1650 - TABLE_DEPTH - 40) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      dim_bits = $urandom_range(6, 31);
      shp = $urandom_range(0, 3);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 40);
      load_table(len, $urandom_range(2, 30));
      drain();
      write_reg(CFG_TABLE_LENGTH, len);
      write_reg(CFG_APERTURE_SHAPE, shp);
      if (!did_hold && len >= 2) begin
        did_hold = 1;
        long_hold_req = 1;
        no_gaps = 1;
      end
      run_checks($urandom_range(30, 70), len);
      drain();
      no_gaps = 0;
    end

    // full table, length register beyond the depth
    dim_bits = 31;
    load_table(TABLE_DEPTH, 29);
    drain();
    write_reg(CFG_TABLE_LENGTH, 2047);
    write_reg(CFG_APERTURE_SHAPE, SHAPE_ELLIPSE);
    run_checks(20, TABLE_DEPTH);
    drain();
    write_reg(CFG_TABLE_LENGTH, TABLE_DEPTH);
    write_reg(CFG_APERTURE_SHAPE, SHAPE_SPARE);
    run_checks(10, TABLE_DEPTH);
    drain();

    if (fail_count == 0) begin
      $display("interpolated_aperture_check_tb: clean");
    end else begin
      $display("interpolated_aperture_check_tb: errors");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("interpolated_aperture_check_tb: errors");
    $finish;
  end
endmodule
